[sv/lcdws_pkg.sv]
// shared types, request codes and the init command table of the lcd write sequencer
package lcdws_pkg;

	localparam logic [2:0] REQ_INIT  = 3'd0;
	localparam logic [2:0] REQ_CMD   = 3'd1;
	localparam logic [2:0] REQ_DATA  = 3'd2;
	localparam logic [2:0] REQ_CLEAR = 3'd3;
	localparam logic [2:0] REQ_GOTO  = 3'd4;
	localparam logic [2:0] REQ_NUM   = 3'd5;

	localparam logic [7:0] CMD_FUNC_SET  = 8'b0011_1000;
	localparam logic [7:0] CMD_DISP_ON   = 8'b0000_1111;
	localparam logic [7:0] CMD_CLEAR     = 8'b0000_0001;
	localparam logic [7:0] CMD_ENTRY     = 8'b0000_0110;
	localparam logic [1:0] DDRAM_LINE1   = 2'b10;
	localparam logic [1:0] DDRAM_LINE2   = 2'b11;
	localparam logic [7:0] LINE_ONE      = 8'd1;
	localparam logic [7:0] LINE_TWO      = 8'd2;
	localparam logic [7:0] CHAR_MINUS    = 8'h2D;
	localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;

	localparam logic [4:0] HOLD_STD      = 5'd1;
	localparam logic [4:0] HOLD_CLEAR    = 5'd4;
	localparam logic [4:0] HOLD_SETUP    = 5'd2;
	localparam logic [4:0] HOLD_POWER_UP = 5'd30;

	localparam int         NUM_DIGITS    = 10;
	localparam logic [31:0] RECIP_TEN    = 32'hCCCC_CCCD;
	localparam int         RECIP_SHIFT   = 35;
	localparam logic [2:0] INIT_ENTRIES  = 3'd5;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [7:0]         byte_value;
		logic [7:0]         line;
		logic [5:0]         position;
		logic signed [31:0] number;
	} req_t;

	typedef struct packed {
		logic       reg_select;
		logic       read_write;
		logic       enable;
		logic [7:0] bus_data;
		logic [4:0] hold_ms;
		logic       last;
	} res_t;

	// one queued byte write, or the single power-up wait step
	typedef struct packed {
		logic       idle_step;
		logic       rs;
		logic [7:0] value;
		logic [4:0] low_hold;
		logic       last;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_push_t;

	function automatic q_entry_t init_entry(input logic [2:0] idx);
		q_entry_t e;
		e = '0;
		unique case (idx)
			3'd0: begin
				e.idle_step = 1'b1;
				e.low_hold  = HOLD_POWER_UP;
			end
			3'd1: begin
				e.value    = CMD_FUNC_SET;
				e.low_hold = HOLD_SETUP;
			end
			3'd2: begin
				e.value    = CMD_DISP_ON;
				e.low_hold = HOLD_SETUP;
			end
			3'd3: begin
				e.value    = CMD_CLEAR;
				e.low_hold = HOLD_CLEAR;
			end
			3'd4: begin
				e.value    = CMD_ENTRY;
				e.low_hold = HOLD_STD;
				e.last     = 1'b1;
			end
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

[sv/lcdws_front.sv]
// front end: accepts requests, converts numbers to digits and queues byte writes
module lcdws_front import lcdws_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  req_t    request,
	input  logic    q_full,
	output q_push_t push,
	output logic    busy
);

	typedef enum logic [2:0] {F_IDLE, F_INIT, F_MUL, F_DIV, F_SIGN, F_DIG} fstate_t;

	fstate_t     state_q;
	logic [2:0]  idx_q;
	logic        neg_q;
	logic [31:0] mag_q;
	logic [63:0] prod_q;
	logic [3:0]  nd_q;
	logic [3:0]  digit_q [NUM_DIGITS];

	logic [63:0] prod;
	logic [28:0] quot;
	logic [31:0] rem;
	logic [31:0] mag_in;

	assign prod   = mag_q * RECIP_TEN;
	assign quot   = prod_q[63:RECIP_SHIFT];
	assign rem    = mag_q - {quot, 3'b000} - {2'b00, quot, 1'b0};
	assign mag_in = request.number[31] ? (32'd0 - request.number) : request.number;
	assign busy   = (state_q != F_IDLE);

	always_comb begin
		push = '0;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					case (request.req_type)
						REQ_INIT: begin
							push.valid = 1'b1;
							push.entry = init_entry(3'd0);
						end
						REQ_CMD, REQ_DATA: begin
							push.valid          = 1'b1;
							push.entry.rs       = (request.req_type == REQ_DATA);
							push.entry.value    = request.byte_value;
							push.entry.low_hold = HOLD_STD;
							push.entry.last     = 1'b1;
						end
						REQ_CLEAR: begin
							push.valid          = 1'b1;
							push.entry.value    = CMD_CLEAR;
							push.entry.low_hold = HOLD_CLEAR;
							push.entry.last     = 1'b1;
						end
						REQ_GOTO: begin
							push.valid          = (request.line == LINE_ONE) ||
								(request.line == LINE_TWO);
							push.entry.value    = {(request.line == LINE_ONE) ?
								DDRAM_LINE1 : DDRAM_LINE2, request.position};
							push.entry.low_hold = HOLD_STD;
							push.entry.last     = 1'b1;
						end
						default: push = '0;
					endcase
				end
			end
			F_INIT: begin
				push.valid = !q_full;
				push.entry = init_entry(idx_q);
			end
			F_SIGN: begin
				push.valid          = !q_full;
				push.entry.rs       = 1'b1;
				push.entry.value    = CHAR_MINUS;
				push.entry.low_hold = HOLD_STD;
			end
			F_DIG: begin
				push.valid          = !q_full;
				push.entry.rs       = 1'b1;
				push.entry.value    = {CHAR_DIGIT_HI, digit_q[0]};
				push.entry.low_hold = HOLD_STD;
				push.entry.last     = (nd_q == 4'd1);
			end
			default: push = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			idx_q   <= '0;
			nd_q    <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept && request.req_type == REQ_INIT) begin
						idx_q   <= 3'd1;
						state_q <= F_INIT;
					end else if (accept && request.req_type == REQ_NUM) begin
						nd_q    <= '0;
						state_q <= F_MUL;
					end
				end
				F_INIT: begin
					if (!q_full) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == INIT_ENTRIES - 3'd1) state_q <= F_IDLE;
					end
				end
				F_MUL: state_q <= F_DIV;
				F_DIV: begin
					nd_q <= nd_q + 4'd1;
					if (quot == '0) state_q <= neg_q ? F_SIGN : F_DIG;
					else            state_q <= F_MUL;
				end
				F_SIGN: begin
					if (!q_full) state_q <= F_DIG;
				end
				F_DIG: begin
					if (!q_full) begin
						nd_q <= nd_q - 4'd1;
						if (nd_q == 4'd1) state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// datapath of the digit conversion, no reset
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && accept) begin
			neg_q <= request.number[31];
			mag_q <= mag_in;
		end
		if (state_q == F_MUL) prod_q <= prod;
		if (state_q == F_DIV) begin
			mag_q      <= {3'b000, quot};
			digit_q[0] <= rem[3:0];
			for (int i = 1; i < NUM_DIGITS; i++) digit_q[i] <= digit_q[i-1];
		end
		if (state_q == F_DIG && !q_full) begin
			for (int i = 0; i < NUM_DIGITS - 1; i++) digit_q[i] <= digit_q[i+1];
		end
	end

	a_dig_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_DIG || state_q == F_SIGN) |-> (nd_q != 4'd0))
		else $error("digit emission with no digits left");

endmodule

[sv/lcdws_fifo.sv]
// small register queue between the front end and the pin step generator
module lcdws_fifo import lcdws_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  q_push_t  push,
	input  logic     pop,
	output q_entry_t head,
	output logic     full,
	output logic     empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t      mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) wr_q <= nxt(wr_q);
			if (pop)        rd_q <= nxt(rd_q);
			if (push.valid && !pop)      cnt_q <= cnt_q + CW'(1);
			else if (!push.valid && pop) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) mem_q[wr_q] <= push.entry;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.valid && full && !pop))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue underflow");

endmodule

[sv/lcdws_back.sv]
// back end: turns queued byte writes into enable-high and enable-low pin steps
module lcdws_back import lcdws_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  q_entry_t head,
	input  logic     empty,
	output logic     pop,
	output res_t     result,
	output logic     strobe,
	output logic     busy
);

	typedef enum logic {B_IDLE, B_LOW} bstate_t;

	bstate_t  state_q;
	q_entry_t cur_q;
	res_t     result_q;
	logic     strobe_q;

	assign pop    = (state_q == B_IDLE) && !empty;
	assign result = result_q;
	assign strobe = strobe_q;
	assign busy   = (state_q != B_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			strobe_q <= 1'b0;
			cur_q    <= '0;
			result_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						strobe_q            <= 1'b1;
						cur_q               <= head;
						result_q.reg_select <= head.rs;
						result_q.read_write <= 1'b0;
						result_q.bus_data   <= head.value;
						if (head.idle_step) begin
							result_q.enable  <= 1'b0;
							result_q.hold_ms <= head.low_hold;
							result_q.last    <= head.last;
						end else begin
							result_q.enable  <= 1'b1;
							result_q.hold_ms <= HOLD_STD;
							result_q.last    <= 1'b0;
							state_q          <= B_LOW;
						end
					end
				end
				B_LOW: begin
					strobe_q         <= 1'b1;
					result_q.enable  <= 1'b0;
					result_q.hold_ms <= cur_q.low_hold;
					result_q.last    <= cur_q.last;
					state_q          <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_low_follows_high: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && result_q.enable) |=> (strobe_q && !result_q.enable &&
		$stable(result_q.bus_data)))
		else $error("enable high step not followed by its low step");

endmodule

[sv/char_lcd_write_sequencer.sv]
// top level of the character lcd write sequencer
// Takes one request while busy is low and start is high, then drives the pin steps of an
// 8-bit character lcd write on result, one step per cycle while byte writes are queued,
// each marked by strobe. Every byte write is an enable-high step held 1 ms and an
// enable-low step that carries any extra wait. Command, data, clear and go-to requests
// give two steps; init gives the 30 ms power-up step plus four commands, 9 steps. A
// signed number is converted by a reciprocal multiply, a multiply and a divide state per
// decimal digit, then sign and digits stream out two steps per character: up to 22 steps
// for the most negative value. Requests that act on nothing (go-to on a line other than
// 1 or 2, unused request types) give no steps and leave busy low. The receiver cannot
// stall: each step is marked by strobe for exactly one cycle.
module char_lcd_write_sequencer import lcdws_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t request,
	output logic busy,
	output res_t result,
	output logic strobe
);

	logic     accept;
	q_push_t  push;
	q_entry_t head;
	logic     q_full, q_empty, pop;
	logic     front_busy, back_busy;

	// a request is taken only when front, queue and back are all drained
	assign accept = start && !busy;
	assign busy   = front_busy || back_busy || !q_empty;

	// front end: classify the request and queue its byte writes
	lcdws_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.request(request),
		.q_full (q_full),
		.push   (push),
		.busy   (front_busy)
	);

	// decoupling queue of byte writes
	lcdws_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back end: two pin steps per byte, one step per cycle while byte writes are queued
	lcdws_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (q_empty),
		.pop    (pop),
		.result (result),
		.strobe (strobe),
		.busy   (back_busy)
	);

	// nothing is queued unless a request is in flight
	a_push_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (accept || front_busy))
		else $error("byte write queued with no request in flight");

endmodule
